FILE: hw/rtl/gbpe_pkg.sv
`timescale 1ns / 1ps
package gbpe_pkg;

	typedef enum logic [1:0] {
		MODE_MONO  = 2'd0,
		MODE_GRAY  = 2'd1,
		MODE_LCD   = 2'd2,
		MODE_LCD_V = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_MONO = 2'd0;
	localparam logic [1:0] KIND_GRAY = 2'd1;
	localparam logic [1:0] KIND_LCD  = 2'd2;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_BGR    = 3'd1;
	localparam logic [2:0] REG_WIDTH  = 3'd2;
	localparam logic [2:0] REG_ROWS   = 3'd3;
	localparam logic [2:0] REG_PITCH  = 3'd4;
	localparam logic [2:0] REG_ORIG_X = 3'd5;
	localparam logic [2:0] REG_ORIG_Y = 3'd6;

	localparam int X_LSB     = 0;
	localparam int Y_LSB     = 17;
	localparam int RED_LSB   = 34;
	localparam int GREEN_LSB = 42;
	localparam int BLUE_LSB  = 50;

	localparam logic [10:0] ROW_SAT = 11'h7FF;
	localparam logic [1:0]  PHASE_LAST = 2'd2;

	function automatic logic [9:0] div3(input logic [10:0] v);
		logic [21:0] p;
		begin
			p = 22'(v) * 22'd683;
			return p[20:11];
		end
	endfunction

endpackage

FILE: hw/rtl/gbpe_ram.sv
`timescale 1ns / 1ps
module gbpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/glyph_bitmap_pixel_expander.sv
`timescale 1ns / 1ps
// the first pixel write of a byte goes through the expansion stage, then the output register
// throughput: one byte per cycle in gray and lcd modes unless the output stalls; in mono a
// byte holds the expansion stage until the bit walker has issued each of its set pixels
// reset: arst_n clears configuration, valid flags, stream position and held subpixels at once;
// the two line stores are not cleared and hold rubbish until written
module glyph_bitmap_pixel_expander
	import gbpe_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // bitmap_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // pix_x, pix_y, red_level, green_level, blue_level, zero fill
	output logic [1:0]  m_tuser,   // pixel_kind
	output logic        m_tlast
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

	// configuration
	mode_t        mode_q;
	logic         bgr_q;
	logic [10:0]  width_q;
	logic [10:0]  rows_q;
	logic [10:0]  pitch_q;
	logic [15:0]  ox_q;
	logic [15:0]  oy_q;

	// stream position
	logic [10:0]  col_q;
	logic [10:0]  row_q;
	logic [1:0]   cph_q;
	logic [9:0]   col3_q;
	logic [1:0]   rph_q;
	logic [9:0]   row3_q;
	logic [15:0]  held_q;

	// expansion stage
	logic         vld_s1;
	logic [7:0]   mask_s1;
	logic         one_s1;
	logic         vert_s1;
	logic [1:0]   kind_s1;
	logic [10:0]  col_s1;
	logic [10:0]  y_s1;
	logic [7:0]   red_s1;
	logic [7:0]   green_s1;
	logic [7:0]   blue_s1;
	logic [7:0]   byte_s1;

	// output register
	logic         m_tvalid_q;
	logic [16:0]  x_q;
	logic [16:0]  y_q;
	logic [1:0]   kind_q;
	logic [7:0]   red_q;
	logic [7:0]   green_q;
	logic [7:0]   blue_q;
	logic         last_q;

	logic [7:0]   rd0;
	logic [7:0]   rd1;

	logic         accept;
	logic [9:0]   w3;
	logic [9:0]   rows3;
	logic         row_end;
	logic [7:0]   mask_in;
	logic         one_in;
	logic         vert_in;
	logic         vert_act;
	logic [1:0]   kind_in;
	logic [10:0]  col_in;
	logic [10:0]  y_in;
	logic [7:0]   red_in;
	logic [7:0]   green_in;
	logic [7:0]   blue_in;

	logic [7:0]   vr;
	logic [7:0]   vb;
	logic [2:0]   k_sel;
	logic [7:0]   rest;
	logic         want;
	logic         last_c;
	logic         out_load;
	logic         s1_done;
	logic [10:0]  col_out;
	logic [7:0]   red_out;
	logic [7:0]   green_out;
	logic [7:0]   blue_out;

	assign w3    = div3(width_q);
	assign rows3 = div3(rows_q);
	assign row_end = ({1'b0, col_q} + 12'd1) >= {1'b0, pitch_q};

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_GRAY;
			bgr_q   <= 1'b0;
			width_q <= '0;
			rows_q  <= '0;
			pitch_q <= 11'd1;
			ox_q    <= '0;
			oy_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q  <= mode_t'(cfg_data[1:0]);
				REG_BGR:    bgr_q   <= cfg_data[0];
				REG_WIDTH:  width_q <= cfg_data[10:0];
				REG_ROWS:   rows_q  <= cfg_data[10:0];
				REG_PITCH:  pitch_q <= cfg_data[10:0];
				REG_ORIG_X: ox_q    <= cfg_data;
				REG_ORIG_Y: oy_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode of the incoming byte
	always_comb begin
		mask_in  = '0;
		one_in   = 1'b0;
		vert_in  = 1'b0;
		vert_act = 1'b0;
		kind_in  = KIND_GRAY;
		col_in   = col_q;
		y_in     = row_q;
		red_in   = s_tdata;
		green_in = s_tdata;
		blue_in  = s_tdata;
		unique case (mode_q)
			MODE_MONO: begin
				kind_in = KIND_MONO;
				col_in  = {col_q[7:0], 3'b000};
				for (int k = 0; k < 8; k++) begin
					mask_in[k] = (row_q < rows_q) && s_tdata[7-k] &&
						({col_q, 3'(k)} < {3'b000, width_q});
				end
			end
			MODE_GRAY: begin
				one_in = (row_q < rows_q) && (col_q < width_q) && (s_tdata != 8'd0);
			end
			MODE_LCD: begin
				kind_in  = KIND_LCD;
				col_in   = {1'b0, col3_q};
				red_in   = bgr_q ? s_tdata : held_q[7:0];
				green_in = held_q[15:8];
				blue_in  = bgr_q ? held_q[7:0] : s_tdata;
				one_in   = (row_q < rows_q) && (col3_q < w3) && (cph_q == PHASE_LAST) &&
					((red_in | green_in | blue_in) != 8'd0);
			end
			MODE_LCD_V: begin
				kind_in  = KIND_LCD;
				y_in     = {1'b0, row3_q};
				vert_act = (row3_q < rows3) && (col_q < width_q) && ({2'b00, col_q} < MAXW);
				vert_in  = vert_act && (rph_q == PHASE_LAST);
				one_in   = vert_in;
			end
		endcase
	end

	gbpe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line0 (
		.clk   (clk),
		.we    (accept && vert_act && (rph_q == 2'd0)),
		.waddr (AW'(col_q)),
		.wdata (s_tdata),
		.re    (accept && vert_in),
		.raddr (AW'(col_q)),
		.rdata (rd0)
	);

	gbpe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
		.clk   (clk),
		.we    (accept && vert_act && (rph_q == 2'd1)),
		.waddr (AW'(col_q)),
		.wdata (s_tdata),
		.re    (accept && vert_in),
		.raddr (AW'(col_q)),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			cph_q  <= '0;
			col3_q <= '0;
			rph_q  <= '0;
			row3_q <= '0;
			held_q <= '0;
		end else if (accept) begin
			if (mode_q == MODE_LCD && row_q < rows_q && col3_q < w3) begin
				if (cph_q == 2'd0) begin
					held_q <= {8'h00, s_tdata};
				end else if (cph_q == 2'd1) begin
					held_q[15:8] <= s_tdata;
				end
			end
			if (row_end) begin
				col_q  <= '0;
				cph_q  <= '0;
				col3_q <= '0;
				if (row_q != ROW_SAT) begin
					row_q <= row_q + 11'd1;
					if (rph_q == PHASE_LAST) begin
						rph_q  <= '0;
						row3_q <= row3_q + 10'd1;
					end else begin
						rph_q <= rph_q + 2'd1;
					end
				end
			end else begin
				col_q <= col_q + 11'd1;
				if (cph_q == PHASE_LAST) begin
					cph_q  <= '0;
					col3_q <= col3_q + 10'd1;
				end else begin
					cph_q <= cph_q + 2'd1;
				end
			end
		end
	end

	// expansion: one pixel write per cycle while the output is not stalled
	always_comb begin
		k_sel = '0;
		for (int k = 7; k >= 0; k--) begin
			if (mask_s1[k]) begin
				k_sel = 3'(k);
			end
		end
		rest = mask_s1 & ~(8'd1 << k_sel);
		vr   = bgr_q ? byte_s1 : rd0;
		vb   = bgr_q ? rd0 : byte_s1;
		if (kind_s1 == KIND_MONO) begin
			want      = vld_s1 && (mask_s1 != 8'd0);
			last_c    = (rest == 8'd0);
			col_out   = {col_s1[10:3], k_sel};
			red_out   = 8'hFF;
			green_out = 8'hFF;
			blue_out  = 8'hFF;
		end else if (vert_s1) begin
			want      = vld_s1 && one_s1 && ((vr | rd1 | vb) != 8'd0);
			last_c    = 1'b1;
			col_out   = col_s1;
			red_out   = vr;
			green_out = rd1;
			blue_out  = vb;
		end else begin
			want      = vld_s1 && one_s1;
			last_c    = 1'b1;
			col_out   = col_s1;
			red_out   = red_s1;
			green_out = green_s1;
			blue_out  = blue_s1;
		end
		out_load = want && (!m_tvalid_q || m_tready);
		s1_done  = vld_s1 && (!want || (out_load && last_c));
	end

	assign s_tready = !vld_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_s1  <= mask_in;
			one_s1   <= one_in;
			vert_s1  <= vert_in;
			kind_s1  <= kind_in;
			col_s1   <= col_in;
			y_s1     <= y_in;
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
			byte_s1  <= s_tdata;
		end else if (out_load) begin
			mask_s1 <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			x_q     <= $signed({ox_q[15], ox_q}) + $signed({6'b000000, col_out});
			y_q     <= $signed({oy_q[15], oy_q}) + $signed({6'b000000, y_s1});
			kind_q  <= kind_s1;
			red_q   <= red_out;
			green_q <= green_out;
			blue_q  <= blue_out;
			last_q  <= last_c;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, blue_q, green_q, red_q, y_q, x_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

FILE: hw/rtl/gbpe_checker.sv
`timescale 1ns / 1ps
module gbpe_checker
	import gbpe_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	assign red   = m_tdata[RED_LSB+:8];
	assign green = m_tdata[GREEN_LSB+:8];
	assign blue  = m_tdata[BLUE_LSB+:8];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_MONO || m_tuser == KIND_GRAY || m_tuser == KIND_LCD))
		else $error("bad pixel kind");

	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_MONO |-> red == 8'hFF && green == 8'hFF && blue == 8'hFF)
		else $error("mono pixel not full level");

	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_GRAY |->
			red == green && green == blue && red != 8'd0 && m_tlast)
		else $error("gray pixel levels inconsistent");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (red | green | blue) != 8'd0)
		else $error("empty pixel written");

endmodule

bind glyph_bitmap_pixel_expander gbpe_checker u_gbpe_checker (.*);

FILE: test/tb_glyph_bitmap_pixel_expander.sv
`timescale 1ns / 1ps
module tb_glyph_bitmap_pixel_expander;
	import gbpe_pkg::*;

	localparam int LINE_DEPTH = 1024;

	typedef struct packed {
		logic [16:0] x;
		logic [16:0] y;
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        last;
	} pixel_write_t;

	typedef struct packed {
		logic         is_reg;
		logic [2:0]   idx;
		logic [15:0]  value;
		int           n_typed;
		pixel_write_t px;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_MODE;
	logic [15:0] cfg_data = 16'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int stim_tag = -1;
	bit gaps_on = 1'b1;
	bit hold_armed = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int mismatches = 0;

	// predictor state
	mode_t      mode_q = MODE_GRAY;
	logic       bgr_q = 1'b0;
	int         width_q = 0;
	int         rows_q = 0;
	int         pitch_q = 1;
	int         org_x = 0;
	int         org_y = 0;
	int         col_pos = 0;
	int         row_pos = 0;
	logic [15:0] held = 16'd0;
	logic [7:0] top_subrow [LINE_DEPTH];
	logic [7:0] mid_subrow [LINE_DEPTH];

	pixel_write_t fresh_writes[$];
	pixel_write_t writes_due[$];
	pixel_write_t head_write;
	step_t        script[$];

	glyph_bitmap_pixel_expander #(.MAX_WIDTH(LINE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic pixel_write_t pixel_at(input int col, input int row, input logic [1:0] kind,
		input logic [7:0] rd, input logic [7:0] gr, input logic [7:0] bl);
		pixel_write_t p;
		p.x = 17'(org_x + col);
		p.y = 17'(org_y + row);
		p.kind = kind;
		p.red = rd;
		p.green = gr;
		p.blue = bl;
		p.last = 1'b0;
		return p;
	endfunction

	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			REG_MODE: mode_q = mode_t'(data[1:0]);
			REG_BGR: bgr_q = data[0];
			REG_WIDTH: width_q = data[10:0];
			REG_ROWS: rows_q = data[10:0];
			REG_PITCH: pitch_q = data[10:0];
			REG_ORIG_X: org_x = $signed(data);
			REG_ORIG_Y: org_y = $signed(data);
			default: ;
		endcase
	endfunction

	function automatic void expand_byte(input logic [7:0] b);
		int c, r, col, span;
		logic [7:0] s0, s1, rr, bb;
		c = col_pos;
		r = row_pos;
		fresh_writes.delete();
		case (mode_q)
			MODE_MONO: begin
				if (r < rows_q) begin
					for (int k = 0; k < 8; k++) begin
						col = c * 8 + k;
						if (col >= width_q)
							break;
						if (b[7 - k])
							fresh_writes.push_back(pixel_at(col, r, KIND_MONO, 8'hFF, 8'hFF, 8'hFF));
					end
				end
			end
			MODE_GRAY: begin
				if (r < rows_q && c < width_q && b != 8'd0)
					fresh_writes.push_back(pixel_at(c, r, KIND_GRAY, b, b, b));
			end
			MODE_LCD: begin
				span = (width_q / 3) * 3;
				if (r < rows_q && c < span) begin
					case (c % 3)
						0: held = {8'd0, b};
						1: held[15:8] = b;
						default: begin
							s0 = held[7:0];
							s1 = held[15:8];
							rr = bgr_q ? b : s0;
							bb = bgr_q ? s0 : b;
							if ((rr | s1 | bb) != 8'd0)
								fresh_writes.push_back(pixel_at(c / 3, r, KIND_LCD, rr, s1, bb));
						end
					endcase
				end
			end
			default: begin
				span = (rows_q / 3) * 3;
				if (r < span && c < width_q && c < LINE_DEPTH) begin
					case (r % 3)
						0: top_subrow[c] = b;
						1: mid_subrow[c] = b;
						default: begin
							s0 = top_subrow[c];
							s1 = mid_subrow[c];
							rr = bgr_q ? b : s0;
							bb = bgr_q ? s0 : b;
							if ((rr | s1 | bb) != 8'd0)
								fresh_writes.push_back(pixel_at(c, r / 3, KIND_LCD, rr, s1, bb));
						end
					endcase
				end
			end
		endcase
		if (fresh_writes.size() > 0)
			fresh_writes[fresh_writes.size() - 1].last = 1'b1;
		if (c + 1 >= pitch_q) begin
			col_pos = 0;
			if (row_pos < int'(ROW_SAT))
				row_pos = row_pos + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic void check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && cfg_we)
			apply_reg(cfg_index, cfg_data);
		if (arst_n && s_tvalid && s_tready) begin
			expand_byte(s_tdata);
			if (stim_tag >= 0 && script[stim_tag].n_typed >= 0) begin
				if (script[stim_tag].n_typed > 0)
					writes_due.push_back(script[stim_tag].px);
			end else begin
				foreach (fresh_writes[i])
					writes_due.push_back(fresh_writes[i]);
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (writes_due.size() == 0) begin
				$display("%0t: pixel write expected none got x %0h y %0h", $time,
					m_tdata[16:0], m_tdata[33:17]);
				mismatches++;
			end else begin
				head_write = writes_due.pop_front();
				check_field("pix_x", head_write.x, m_tdata[16:0]);
				check_field("pix_y", head_write.y, m_tdata[33:17]);
				check_field("red_level", head_write.red, m_tdata[41:34]);
				check_field("green_level", head_write.green, m_tdata[49:42]);
				check_field("blue_level", head_write.blue, m_tdata[57:50]);
				check_field("zero fill", 0, m_tdata[63:58]);
				check_field("pixel_kind", head_write.kind, m_tuser);
				check_field("last_of_run", head_write.last, m_tlast);
			end
		end
	end

	// receiver, with one long hold-off so the block backs up
	always @(posedge clk) begin
		if (hold_armed && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !(gaps_on && $urandom_range(0, 99) < 32);
		end
	end

	function automatic step_t reg_row(input logic [2:0] idx, input logic [15:0] value);
		step_t s;
		s = '0;
		s.is_reg = 1'b1;
		s.idx = idx;
		s.value = value;
		return s;
	endfunction

	function automatic step_t byte_row(input logic [7:0] b, input int n_typed);
		step_t s;
		s = '0;
		s.value = {8'd0, b};
		s.n_typed = n_typed;
		return s;
	endfunction

	function automatic step_t pixel_row(input logic [7:0] b, input int x, input int y,
		input logic [1:0] kind, input logic [7:0] rd, input logic [7:0] gr, input logic [7:0] bl);
		step_t s;
		s = byte_row(b, 1);
		s.px.x = 17'(x);
		s.px.y = 17'(y);
		s.px.kind = kind;
		s.px.red = rd;
		s.px.green = gr;
		s.px.blue = bl;
		s.px.last = 1'b1;
		return s;
	endfunction

	task automatic push_byte(input logic [7:0] b, input int tag);
		while (gaps_on && $urandom_range(0, 99) < 32) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		stim_tag <= tag;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (writes_due.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic close_regs();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic phase_regs(input mode_t m, input logic bgr, input int width, input int rows,
		input int pitch, input logic [15:0] ox, input logic [15:0] oy);
		put_reg(REG_MODE, {14'd0, m});
		put_reg(REG_BGR, {15'd0, bgr});
		put_reg(REG_WIDTH, 16'(width));
		put_reg(REG_ROWS, 16'(rows));
		put_reg(REG_PITCH, 16'(pitch));
		put_reg(REG_ORIG_X, ox);
		put_reg(REG_ORIG_Y, oy);
		close_regs();
	endtask

	function automatic logic [7:0] next_byte(input bit sparse);
		int sel;
		sel = $urandom_range(0, 19);
		if (sparse)
			return (sel < 2) ? 8'($urandom) : 8'h00;
		if (sel < 6)
			return 8'h00;
		if (sel < 8)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [15:0] pick_origin();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic build_script();
		script.push_back(byte_row(8'hFF, 0));
		script.push_back(reg_row(REG_WIDTH, 16'd1024));
		script.push_back(reg_row(REG_ROWS, 16'd1024));
		script.push_back(reg_row(REG_ORIG_X, 16'h7FFF));
		script.push_back(reg_row(REG_ORIG_Y, 16'h8000));
		script.push_back(pixel_row(8'hFF, 32767, -32767, KIND_GRAY, 8'hFF, 8'hFF, 8'hFF));
		script.push_back(byte_row(8'h00, 0));
		script.push_back(pixel_row(8'h01, 32767, -32765, KIND_GRAY, 8'h01, 8'h01, 8'h01));
		script.push_back(reg_row(REG_MODE, {14'd0, MODE_MONO}));
		script.push_back(reg_row(REG_PITCH, 16'd2));
		script.push_back(reg_row(REG_WIDTH, 16'd11));
		script.push_back(reg_row(REG_ORIG_X, 16'h8000));
		script.push_back(reg_row(REG_ORIG_Y, 16'h7FFF));
		script.push_back(byte_row(8'hFF, -1));
		script.push_back(byte_row(8'hFF, -1));
		script.push_back(pixel_row(8'h80, -32768, 32772, KIND_MONO, 8'hFF, 8'hFF, 8'hFF));
		script.push_back(pixel_row(8'h20, -32758, 32772, KIND_MONO, 8'hFF, 8'hFF, 8'hFF));
		script.push_back(reg_row(REG_PITCH, 16'd3));
		script.push_back(byte_row(8'h55, -1));
		script.push_back(byte_row(8'h01, 0));
		// padding byte past the last pixel column
		script.push_back(byte_row(8'hFF, 0));
		script.push_back(reg_row(REG_MODE, {14'd0, MODE_LCD}));
		script.push_back(reg_row(REG_WIDTH, 16'd7));
		script.push_back(reg_row(REG_PITCH, 16'd8));
		script.push_back(reg_row(REG_ORIG_X, 16'd0));
		script.push_back(reg_row(REG_ORIG_Y, 16'd0));
		script.push_back(byte_row(8'h11, 0));
		script.push_back(byte_row(8'h22, 0));
		script.push_back(pixel_row(8'h33, 0, 7, KIND_LCD, 8'h11, 8'h22, 8'h33));
		script.push_back(byte_row(8'h00, 0));
		script.push_back(byte_row(8'h00, 0));
		script.push_back(byte_row(8'h00, 0));
		// leftover subpixel, then padding
		script.push_back(byte_row(8'h77, 0));
		script.push_back(byte_row(8'h88, 0));
		script.push_back(reg_row(REG_BGR, 16'd1));
		script.push_back(reg_row(REG_PITCH, 16'd3));
		script.push_back(byte_row(8'h11, 0));
		script.push_back(byte_row(8'h22, 0));
		script.push_back(pixel_row(8'h33, 0, 8, KIND_LCD, 8'h33, 8'h22, 8'h11));
		script.push_back(reg_row(REG_MODE, {14'd0, MODE_LCD_V}));
		script.push_back(reg_row(REG_WIDTH, 16'd1));
		script.push_back(reg_row(REG_PITCH, 16'd0));
		script.push_back(byte_row(8'h10, 0));
		script.push_back(byte_row(8'h20, 0));
		script.push_back(pixel_row(8'h30, 0, 3, KIND_LCD, 8'h30, 8'h20, 8'h10));
	endtask

	initial begin
		int fed, phase, pitch, eff, width, rows, sel, nrows;
		bit regs_open, bytes_open;
		mode_t m;
		build_script();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		regs_open = 1'b0;
		bytes_open = 1'b0;
		foreach (script[i]) begin
			if (script[i].is_reg) begin
				if (bytes_open)
					drain();
				put_reg(script[i].idx, script[i].value);
				regs_open = 1'b1;
				bytes_open = 1'b0;
			end else begin
				if (regs_open)
					close_regs();
				push_byte(script[i].value[7:0], i);
				regs_open = 1'b0;
				bytes_open = 1'b1;
			end
		end
		drain();

		// every phase starts on a row boundary with the row index a multiple of three,
		// so lcd-vertical never reads a line store entry it has not written
		fed = 0;
		phase = 0;
		while (fed < 460) begin
			m = mode_t'($urandom_range(0, 3));
			sel = $urandom_range(0, 19);
			pitch = (sel == 0) ? 0 : $urandom_range(1, 16);
			eff = (pitch == 0) ? 1 : pitch;
			width = (m == MODE_MONO) ? $urandom_range(0, eff * 8 + 3) : $urandom_range(0, eff + 2);
			if ($urandom_range(0, 9) == 0)
				width = 1024;
			rows = row_pos + $urandom_range(0, 9);
			if (sel == 1)
				rows = 0;
			else if (sel == 2 || rows > 1024)
				rows = 1024;
			nrows = 3 * $urandom_range(1, 2);
			if (phase == 0) begin
				m = MODE_MONO;
				pitch = 8;
				eff = 8;
				width = 64;
				rows = 1024;
				nrows = 6;
				hold_armed = 1'b1;
			end
			gaps_on = !(phase == 3 || phase == 4);
			phase_regs(m, 1'($urandom), width, rows, pitch, pick_origin(), pick_origin());
			repeat (nrows * eff) push_byte(next_byte(1'b0), -1);
			fed += nrows * eff;
			drain();
			if (phase == 1) begin
				// one full-size lcd-vertical pixel row, mostly empty
				phase_regs(MODE_LCD_V, 1'($urandom), 1024, 1024, 1024, pick_origin(), pick_origin());
				repeat (3 * 1024) push_byte(next_byte(1'b1), -1);
				drain();
			end
			phase++;
		end

		// run the row counter into saturation, then make sure it stays there
		gaps_on = 1'b0;
		phase_regs(MODE_GRAY, 1'b0, 1024, 0, 0, 16'd0, 16'd0);
		repeat (int'(ROW_SAT) - row_pos + 4) push_byte(8'hFF, -1);
		drain();
		put_reg(REG_ROWS, 16'd1024);
		close_regs();
		gaps_on = 1'b1;
		repeat (8) push_byte(8'hA5, -1);
		drain();

		if (mismatches == 0 && writes_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/gbpe_pkg.sv
hw/rtl/gbpe_ram.sv
hw/rtl/glyph_bitmap_pixel_expander.sv
hw/rtl/gbpe_checker.sv
test/tb_glyph_bitmap_pixel_expander.sv
